// ----- rtl/iee_pkg.sv -----
// Package for the infix expression evaluator: operator and status codes,
// controller states, command/status structs. No dependencies.
`timescale 1ns / 1ps
package iee_pkg;
  localparam int unsigned StackDepthDef = 32;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OpW = 3;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
    OP_DIV = 3'd4, OP_LPAR = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BADCHAR = 3'd1, ST_MALFORMED = 3'd2,
    ST_DIVZERO = 3'd3, ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RPAR, S_OPER, S_FLUSH, S_RED_RD, S_RED_EX, S_DIV,
    S_PUSH, S_FINAL, S_RD0, S_OUT
  } state_e;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // commands from controller to datapath
  typedef struct packed {
    logic op_pop;       // drop top operator
    logic op_push;      // push op_code
    op_e  op_code;
    logic val_push_dig; // push digit from char register
    logic val_read;     // read two top values
    logic red_start;    // start arithmetic on read values
    logic val_push_res; // push arithmetic result
    logic rd_bottom;    // read bottom value for output
    logic clear;        // reset counts after output
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op_top;
    logic op_empty;
    logic op_full;
    logic val_full;
    logic val_lt2;
    logic val_one;
    logic div_busy;
    logic div_zero;
  } stat_t;

  function automatic logic prec_hi(op_e op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction
endpackage

// ----- rtl/iee_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle, truncating signed.
// Depends on iee_pkg (none beyond file order).
`timescale 1ns / 1ps
module iee_divider #(
  parameter int unsigned ValueWidth = iee_pkg::ValueWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ValueWidth-1:0] a_i,
  input  logic [ValueWidth-1:0] b_i,
  output logic                  busy_o,
  output logic [ValueWidth-1:0] q_o
);
  localparam int unsigned CntW = $clog2(ValueWidth + 1);
  logic [ValueWidth-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d, busy_q, busy_d;
  logic [ValueWidth:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    trial = '0;
    if (start_i) begin
      rem_d = '0;
      quo_d = a_i[ValueWidth-1] ? (~a_i + 1'b1) : a_i;
      dvs_d = b_i[ValueWidth-1] ? (~b_i + 1'b1) : b_i;
      neg_d = a_i[ValueWidth-1] ^ b_i[ValueWidth-1];
      cnt_d = CntW'(ValueWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[ValueWidth-1]} - {1'b0, dvs_q};
      if (!trial[ValueWidth]) begin
        rem_d = trial[ValueWidth-1:0];
        quo_d = {quo_q[ValueWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
        quo_d = {quo_q[ValueWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign q_o = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

// ----- rtl/iee_datapath.sv -----
// Datapath: operator stack, value stack memory, ALU and divider.
// Depends on iee_pkg and iee_divider.
`timescale 1ns / 1ps
module iee_datapath #(
  parameter int unsigned StackDepth = iee_pkg::StackDepthDef,
  parameter int unsigned ValueWidth = iee_pkg::ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iee_pkg::cmd_t          cmd_i,
  input  logic [3:0]             digit_i,
  output iee_pkg::stat_t         stat_o,
  output logic [ValueWidth-1:0]  result_o
);
  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CW = $clog2(StackDepth + 1);

  iee_pkg::op_e op_mem [StackDepth];
  logic [ValueWidth-1:0] val_mem [StackDepth];
  logic [CW-1:0] opc_q, valc_q;
  iee_pkg::op_e op_top_q;
  logic [ValueWidth-1:0] a_q, b_q, res_q, rd_q;
  iee_pkg::op_e alu_op_q;
  logic div_busy;
  logic [ValueWidth-1:0] div_q;
  logic [CW-1:0] opc_m1, opc_m2, valc_m1, valc_m2;

  assign opc_m1 = opc_q - 1'b1;
  assign opc_m2 = opc_q - CW'(2);
  assign valc_m1 = valc_q - 1'b1;
  assign valc_m2 = valc_q - CW'(2);

  // operator stack: top cached in a register, pop re-reads below
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_push) op_mem[opc_q[AW-1:0]] <= cmd_i.op_code;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) opc_q <= '0;
    else if (cmd_i.clear) opc_q <= '0;
    else if (cmd_i.op_push) opc_q <= opc_q + 1'b1;
    else if (cmd_i.op_pop) opc_q <= opc_m1;
  end
  // top-of-stack register, valid from the cycle after a push or pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_push) op_top_q <= cmd_i.op_code;
    else if (cmd_i.op_pop) begin
      if (opc_q >= CW'(2)) op_top_q <= op_mem[opc_m2[AW-1:0]];
      else op_top_q <= iee_pkg::OP_NONE;
    end
  end

  // value stack memory, one write port; registered reads of top two and bottom
  always_ff @(posedge clk_i) begin
    if (cmd_i.val_push_dig)
      val_mem[valc_q[AW-1:0]] <= ValueWidth'(digit_i);
    else if (cmd_i.val_push_res)
      val_mem[valc_q[AW-1:0]] <= res_q;
    if (cmd_i.val_read) begin
      b_q <= val_mem[valc_m1[AW-1:0]];
      a_q <= val_mem[valc_m2[AW-1:0]];
    end
    if (cmd_i.rd_bottom) rd_q <= val_mem[0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valc_q <= '0;
    else if (cmd_i.clear) valc_q <= '0;
    else if (cmd_i.val_push_dig || cmd_i.val_push_res) valc_q <= valc_q + 1'b1;
    else if (cmd_i.val_read) valc_q <= valc_m2;
  end

  iee_divider #(.ValueWidth(ValueWidth)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.red_start && cmd_i.op_code == iee_pkg::OP_DIV),
    .a_i(a_q), .b_i(b_q), .busy_o(div_busy), .q_o(div_q)
  );

  logic [2*ValueWidth-1:0] prod;
  assign prod = a_q * b_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.red_start) begin
      alu_op_q <= cmd_i.op_code;
      case (cmd_i.op_code)
        iee_pkg::OP_ADD: res_q <= a_q + b_q;
        iee_pkg::OP_SUB: res_q <= a_q - b_q;
        iee_pkg::OP_MUL: res_q <= prod[ValueWidth-1:0];
        default:         res_q <= res_q;
      endcase
    end else if (alu_op_q == iee_pkg::OP_DIV && div_busy) begin
      res_q <= res_q;
    end else if (alu_op_q == iee_pkg::OP_DIV) begin
      res_q <= div_q;
    end
  end

  assign stat_o.op_top = op_top_q;
  assign stat_o.op_empty = (opc_q == '0);
  assign stat_o.op_full = (opc_q >= CW'(StackDepth));
  assign stat_o.val_full = (valc_q >= CW'(StackDepth));
  assign stat_o.val_lt2 = (valc_q < CW'(2));
  assign stat_o.val_one = (valc_q == CW'(1));
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_zero = (b_q == '0);
  assign result_o = rd_q;
endmodule

// ----- rtl/iee_controller.sv -----
// Controller state machine: decodes characters, sequences reductions and flush.
// Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [3:0]          digit_o,
  output iee_pkg::cmd_t       cmd_o,
  input  iee_pkg::stat_t      stat_i
);
  iee_pkg::state_e state_q, state_d, ret_q, ret_d;
  iee_pkg::status_e err_q, err_d;
  logic [7:0] ch_q;
  logic last_q;
  iee_pkg::op_e cur_q, cur_d, red_q, red_d;
  logic outv_q, outv_d;
  logic [2:0] ostat_q, ostat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iee_pkg::S_IDLE; ret_q <= iee_pkg::S_IDLE;
      err_q <= iee_pkg::ST_OK; outv_q <= 1'b0; ostat_q <= '0;
      cur_q <= iee_pkg::OP_NONE; red_q <= iee_pkg::OP_NONE;
    end else begin
      state_q <= state_d; ret_q <= ret_d; err_q <= err_d;
      outv_q <= outv_d; ostat_q <= ostat_d; cur_q <= cur_d; red_q <= red_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= char_i;
      last_q <= last_i;
    end
  end

  assign in_ready_o = (state_q == iee_pkg::S_IDLE);
  assign out_valid_o = outv_q;
  assign status_o = ostat_q;
  assign digit_o = 4'(ch_q - iee_pkg::ChZero);

  always_comb begin
    state_d = state_q; ret_d = ret_q; err_d = err_q; cur_d = cur_q; red_d = red_q;
    outv_d = outv_q; ostat_d = ostat_q;
    cmd_o = '0;
    cmd_o.op_code = red_q;
    if (outv_q && out_ready_i) outv_d = 1'b0;
    case (state_q)
      iee_pkg::S_IDLE: begin
        if (in_valid_i) state_d = iee_pkg::S_RPAR;  // decode stage
      end
      iee_pkg::S_RPAR: begin
        // decode the held character
        state_d = last_q ? iee_pkg::S_FLUSH : iee_pkg::S_IDLE;
        if (err_q == iee_pkg::ST_OK) begin
          if (ch_q == iee_pkg::ChSpace) begin
          end else if (ch_q >= iee_pkg::ChZero && ch_q <= iee_pkg::ChNine) begin
            if (stat_i.val_full) err_d = iee_pkg::ST_OVERFLOW;
            else cmd_o.val_push_dig = 1'b1;
          end else if (ch_q == iee_pkg::ChLpar) begin
            if (stat_i.op_full) err_d = iee_pkg::ST_OVERFLOW;
            else begin
              cmd_o.op_push = 1'b1; cmd_o.op_code = iee_pkg::OP_LPAR;
            end
          end else if (ch_q == iee_pkg::ChRpar) begin
            cur_d = iee_pkg::OP_LPAR; state_d = iee_pkg::S_OPER;
          end else if (ch_q == iee_pkg::ChPlus) begin
            cur_d = iee_pkg::OP_ADD; state_d = iee_pkg::S_OPER;
          end else if (ch_q == iee_pkg::ChMinus) begin
            cur_d = iee_pkg::OP_SUB; state_d = iee_pkg::S_OPER;
          end else if (ch_q == iee_pkg::ChStar) begin
            cur_d = iee_pkg::OP_MUL; state_d = iee_pkg::S_OPER;
          end else if (ch_q == iee_pkg::ChSlash) begin
            cur_d = iee_pkg::OP_DIV; state_d = iee_pkg::S_OPER;
          end else err_d = iee_pkg::ST_BADCHAR;
        end
      end
      iee_pkg::S_OPER: begin
        // cur_q == LPAR stands for ')' here
        if (err_q != iee_pkg::ST_OK) begin
          state_d = last_q ? iee_pkg::S_FLUSH : iee_pkg::S_IDLE;
        end else if (cur_q == iee_pkg::OP_LPAR) begin
          if (stat_i.op_empty) begin
            state_d = last_q ? iee_pkg::S_FLUSH : iee_pkg::S_IDLE;
          end else if (stat_i.op_top == iee_pkg::OP_LPAR) begin
            cmd_o.op_pop = 1'b1;
            state_d = last_q ? iee_pkg::S_FLUSH : iee_pkg::S_IDLE;
          end else begin
            cmd_o.op_pop = 1'b1; red_d = stat_i.op_top;
            ret_d = iee_pkg::S_OPER; state_d = iee_pkg::S_RED_RD;
          end
        end else begin
          if (!stat_i.op_empty && stat_i.op_top != iee_pkg::OP_LPAR &&
              !(!iee_pkg::prec_hi(stat_i.op_top) && iee_pkg::prec_hi(cur_q))) begin
            cmd_o.op_pop = 1'b1; red_d = stat_i.op_top;
            ret_d = iee_pkg::S_OPER; state_d = iee_pkg::S_RED_RD;
          end else begin
            if (stat_i.op_full) err_d = iee_pkg::ST_OVERFLOW;
            else begin
              cmd_o.op_push = 1'b1; cmd_o.op_code = cur_q;
            end
            state_d = last_q ? iee_pkg::S_FLUSH : iee_pkg::S_IDLE;
          end
        end
      end
      iee_pkg::S_FLUSH: begin
        if (err_q != iee_pkg::ST_OK || stat_i.op_empty) begin
          state_d = iee_pkg::S_FINAL;
        end else if (stat_i.op_top == iee_pkg::OP_LPAR) begin
          cmd_o.op_pop = 1'b1;
        end else begin
          cmd_o.op_pop = 1'b1; red_d = stat_i.op_top;
          ret_d = iee_pkg::S_FLUSH; state_d = iee_pkg::S_RED_RD;
        end
      end
      iee_pkg::S_RED_RD: begin
        if (stat_i.val_lt2) begin
          err_d = iee_pkg::ST_MALFORMED; state_d = ret_q;
        end else begin
          cmd_o.val_read = 1'b1; state_d = iee_pkg::S_RED_EX;
        end
      end
      iee_pkg::S_RED_EX: begin
        if (red_q == iee_pkg::OP_DIV && stat_i.div_zero) begin
          err_d = iee_pkg::ST_DIVZERO; state_d = ret_q;
        end else begin
          cmd_o.red_start = 1'b1;
          state_d = (red_q == iee_pkg::OP_DIV) ? iee_pkg::S_DIV : iee_pkg::S_PUSH;
        end
      end
      iee_pkg::S_DIV: begin
        if (!stat_i.div_busy) state_d = iee_pkg::S_PUSH;
      end
      iee_pkg::S_PUSH: begin
        cmd_o.val_push_res = 1'b1; state_d = ret_q;
      end
      iee_pkg::S_FINAL: begin
        if (err_q == iee_pkg::ST_OK && !stat_i.val_one) err_d = iee_pkg::ST_MALFORMED;
        state_d = iee_pkg::S_RD0;
      end
      iee_pkg::S_RD0: begin
        cmd_o.rd_bottom = 1'b1;
        if (!outv_q || out_ready_i) state_d = iee_pkg::S_OUT;
      end
      iee_pkg::S_OUT: begin
        outv_d = 1'b1; ostat_d = err_q;
        cmd_o.clear = 1'b1; err_d = iee_pkg::ST_OK;
        state_d = iee_pkg::S_IDLE;
      end
      default: state_d = iee_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != iee_pkg::S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)))
    else $error("result dropped");
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != iee_pkg::ST_OK && state_q != iee_pkg::S_OUT) |=> $stable(err_q))
    else $error("error overwritten");
`endif
endmodule

// ----- rtl/infix_expression_evaluator.sv -----
// Top level of the infix expression evaluator: wires controller and datapath.
// Depends on iee_pkg, iee_controller, iee_datapath.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_axis_*: one ASCII character per transaction in tdata,
//   tlast marks the final character of an expression.
//   Master channel m_axis_*: one result transaction per expression, given
//   after the tlast character; tdata = {status[34:32], value[31:0]} padded.
// Sequencing: a digit, space or '(' passes the decode state, then ready
//   returns. An operator or ')' enters the operator state, which pops a '('
//   and reduces each popped + - * or / via read, execute and push states; a
//   / also waits on the bit-serial divider (one quotient bit per cycle). The
//   closing flush walks the stack alike, then final, read and output states.
// The result sits in an output register, so the block accepts the next
//   character while a result waits; a further result waits until taken.
// Reset clears all counts, status and the output valid; stack contents
//   need no clearing since entries above the counts are never read.
// Value is 0 in every error case.
module infix_expression_evaluator #(
  parameter int unsigned StackDepth = iee_pkg::StackDepthDef,
  parameter int unsigned ValueWidth = iee_pkg::ValueWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] value, [34:32] status
);
  iee_pkg::cmd_t cmd;
  iee_pkg::stat_t stat;
  logic [3:0] digit;
  logic [ValueWidth-1:0] result;
  logic [2:0] status;
  logic [31:0] val_q;

  iee_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .digit_o(digit), .cmd_o(cmd), .stat_i(stat)
  );

  iee_datapath #(.StackDepth(StackDepth), .ValueWidth(ValueWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .digit_i(digit), .stat_o(stat), .result_o(result)
  );

  // output value register, loaded with the result transaction
  logic [63:0] res_ext;
  assign res_ext = 64'(signed'(result));
  always_ff @(posedge clk_i) begin
    if (cmd.clear) val_q <= res_ext[31:0];
  end

  assign m_axis_tdata = {5'b0, status, (status == iee_pkg::ST_OK) ? val_q : 32'd0};
endmodule

// ----- tb/sv/tb_infix_expression_evaluator.sv -----
// Testbench for infix_expression_evaluator: character streams in, checked results out.
// Depends on iee_pkg and the RTL top; self-contained otherwise.
`timescale 1ns / 1ps
module tb_infix_expression_evaluator;

  localparam int Depth = 32;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [31:0]      value;
    iee_pkg::status_e status;
  } outcome_t;

  // Scoreboard: holds its own evaluator state and the queue of pending outcomes.
  class expr_scoreboard;
    iee_pkg::op_e     ops[Depth];
    int               n_ops;
    logic [31:0]      vals[Depth];
    int               n_vals;
    iee_pkg::status_e err;
    outcome_t         pending[$];
    int               fails;

    function void clear_state();
      n_ops = 0;
      n_vals = 0;
      err = iee_pkg::ST_OK;
    endfunction

    function void flag(iee_pkg::status_e s);
      if (err == iee_pkg::ST_OK) err = s;
    endfunction

    function void push_val(logic [31:0] v);
      if (n_vals >= Depth) flag(iee_pkg::ST_OVERFLOW);
      else begin
        vals[n_vals] = v;
        n_vals++;
      end
    endfunction

    function void push_op(iee_pkg::op_e o);
      if (n_ops >= Depth) flag(iee_pkg::ST_OVERFLOW);
      else begin
        ops[n_ops] = o;
        n_ops++;
      end
    endfunction

    function bit is_hi(iee_pkg::op_e o);
      return (o == iee_pkg::OP_MUL) || (o == iee_pkg::OP_DIV);
    endfunction

    // apply operator to second-from-top and top value
    function void apply_op(iee_pkg::op_e o);
      logic signed [31:0] a, b, r;
      if (n_vals < 2) begin
        flag(iee_pkg::ST_MALFORMED);
        return;
      end
      b = vals[n_vals-1];
      a = vals[n_vals-2];
      n_vals -= 2;
      case (o)
        iee_pkg::OP_ADD: r = a + b;
        iee_pkg::OP_SUB: r = a - b;
        iee_pkg::OP_MUL: r = a * b;
        default: begin
          if (b == 0) begin
            flag(iee_pkg::ST_DIVZERO);
            return;
          end
          // most negative / -1 wraps
          if (a == 32'sh8000_0000 && b == -1) r = a;
          else r = a / b;
        end
      endcase
      push_val(r);
    endfunction

    function void take_char(logic [7:0] c);
      iee_pkg::op_e o;
      if (c == iee_pkg::ChSpace) return;
      if (c >= iee_pkg::ChZero && c <= iee_pkg::ChNine) begin
        push_val(32'(c - iee_pkg::ChZero));
        return;
      end
      if (c == iee_pkg::ChLpar) begin
        push_op(iee_pkg::OP_LPAR);
        return;
      end
      if (c == iee_pkg::ChRpar) begin
        while (err == iee_pkg::ST_OK && n_ops > 0 && ops[n_ops-1] != iee_pkg::OP_LPAR) begin
          n_ops--;
          apply_op(ops[n_ops]);
        end
        if (err == iee_pkg::ST_OK && n_ops > 0) n_ops--;
        return;
      end
      case (c)
        iee_pkg::ChPlus:  o = iee_pkg::OP_ADD;
        iee_pkg::ChMinus: o = iee_pkg::OP_SUB;
        iee_pkg::ChStar:  o = iee_pkg::OP_MUL;
        iee_pkg::ChSlash: o = iee_pkg::OP_DIV;
        default: begin
          flag(iee_pkg::ST_BADCHAR);
          return;
        end
      endcase
      while (err == iee_pkg::ST_OK && n_ops > 0) begin
        if (ops[n_ops-1] == iee_pkg::OP_LPAR || (!is_hi(ops[n_ops-1]) && is_hi(o))) break;
        n_ops--;
        apply_op(ops[n_ops]);
      end
      if (err == iee_pkg::ST_OK) push_op(o);
    endfunction

    // note one accepted character transaction
    function void note_char(logic [7:0] c, logic last);
      outcome_t res;
      if (err == iee_pkg::ST_OK) take_char(c);
      if (!last) return;
      while (err == iee_pkg::ST_OK && n_ops > 0) begin
        n_ops--;
        if (ops[n_ops] != iee_pkg::OP_LPAR) apply_op(ops[n_ops]);
      end
      if (err == iee_pkg::ST_OK && n_vals != 1) flag(iee_pkg::ST_MALFORMED);
      res.value = (err == iee_pkg::ST_OK) ? vals[0] : 32'd0;
      res.status = err;
      pending.insert(pending.size(), res);
      clear_state();
    endfunction

    function void check_result(logic [39:0] data);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual value %h status %0d",
                 $realtime, data[31:0], data[34:32]);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.value) begin
        $display("%0t: value mismatch, expected %h actual %h",
                 $realtime, want.value, data[31:0]);
        fails++;
      end
      if (data[34:32] !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $realtime, want.status, data[34:32]);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  expr_scoreboard sb = new();
  int  idle_cycles = 0;
  int  n_sent = 0;         // accepted characters
  byte unsigned chars[$];  // expression being built

  always #6 clk_i = ~clk_i;

  infix_expression_evaluator u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Sink: random stalls, check each result transaction.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles with no transaction at all.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // tvalid stays high into the next call when it follows without a gap
  task automatic send_char(byte unsigned c, bit last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_char(c, last);
    n_sent++;
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_expr(string s, bit no_gap = 0);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, no_gap);
  endtask

  function automatic void add_char(byte unsigned c);
    chars.insert(chars.size(), c);
  endfunction

  // Random well-formed expression into chars; depth bounded.
  function automatic void build_expr(int lvl);
    int terms;
    byte unsigned opc[4];
    opc = '{iee_pkg::ChPlus, iee_pkg::ChMinus, iee_pkg::ChStar, iee_pkg::ChSlash};
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        add_char(opc[$urandom_range(0, 3)]);
        if ($urandom_range(0, 4) == 0) add_char(iee_pkg::ChSpace);
      end
      if (lvl < 3 && $urandom_range(0, 3) == 0) begin
        add_char(iee_pkg::ChLpar);
        build_expr(lvl + 1);
        add_char(iee_pkg::ChRpar);
      end else
        add_char(8'(iee_pkg::ChZero + $urandom_range(0, 9)));
    end
  endfunction

  task automatic send_queue(bit no_gap);
    for (int i = 0; i < chars.size(); i++)
      send_char(chars[i], i == chars.size() - 1, no_gap);
  endtask

  initial begin
    string deep;
    int pick;
    bit burst;
    sb.fails = 0;
    sb.clear_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operator, precedence, parentheses and special cases.
    send_expr("1+2*3");
    send_expr("(9-4)/2");
    send_expr("8/3-7");
    send_expr("5/0");
    send_expr("2 + x");
    send_expr("+");
    send_expr("12");
    send_expr(" ");
    send_expr("(3+4");
    send_expr("3)+4");
    send_expr("9*9*9*9*9*9*9*9*9*9*9", 1);    // wraps past 32 bits
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b0);
    // most negative / -1: (0-2)*(8^10) = -2^31 then divided by (0-1)
    send_expr("(0-2)*8*8*8*8*8*8*8*8*8*8/(0-1)");
    deep = "";
    for (int i = 0; i < 33; i++) deep = {deep, "("};
    send_expr({deep, "1"});                    // operator stack overflow
    deep = "";
    for (int i = 0; i < 33; i++) deep = {deep, "1"};
    send_expr(deep, 1);                        // value stack overflow
    send_expr("7/(0-2)");

    // Hold off until every pending result has come back.
    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);

    while (n_sent < 1150) begin
      chars.delete();
      pick = $urandom_range(0, 9);
      if (pick < 7) build_expr(0);
      else if (pick == 7) begin
        build_expr(0);
        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick == 8) begin
        for (int i = $urandom_range(1, 8); i > 0; i--) add_char(8'($urandom_range(0, 255)));
      end else begin
        build_expr(0);
        chars.insert($urandom_range(0, chars.size()), iee_pkg::ChRpar);
        if ($urandom_range(0, 1)) add_char(iee_pkg::ChLpar);
      end
      burst = ($urandom_range(0, 4) == 0);
      send_queue(burst);
    end

    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
